// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks of the frame receiver.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SVA_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SVA_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SVA_SAME(lbl, clk, rst_n, ante, cons, msg)
`define SVA_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: sv/stkfr_pkg.sv
// ----------------------------------------------------------------------------
// Frame receiver package
// Types and constants shared by the frame receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none
package stkfr_pkg;

  localparam logic [7:0] START_BYTE = 8'd27;
  localparam logic [7:0] TOKEN_BYTE = 8'd14;

  localparam logic KIND_BODY = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  body_byte;
    logic [15:0] body_index;
    logic        last_body_byte;
    logic [7:0]  frame_sequence;
    logic [15:0] frame_length;
    logic        checksum_good;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

// File: sv/stkfr_front.sv
// ----------------------------------------------------------------------------
// Frame receiver front end
// Parses the received byte stream and pushes result words into the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module stkfr_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_rx_byte,
  input  wire stkfr_pkg::q_status_t  q_st,
  output logic                       push,
  output stkfr_pkg::res_t            push_data
);
  import stkfr_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT, PH_SEQ, PH_LEN_HI, PH_LEN_LO, PH_TOKEN, PH_BODY, PH_CSUM
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] count_r, count_nxt;
  logic        in_fire;
  logic [16:0] count_inc;
  logic        is_last;

  assign in_ready  = !q_st.full;
  assign in_fire   = in_valid && in_ready;
  assign count_inc = {1'b0, count_r} + 17'd1;
  assign is_last   = (count_inc == {1'b0, len_r});

  always_comb begin
    phase_nxt = phase_r;
    seq_nxt   = seq_r;
    len_nxt   = len_r;
    xor_nxt   = xor_r;
    count_nxt = count_r;
    push      = 1'b0;
    push_data = '0;
    push_data.frame_sequence = seq_r;
    push_data.frame_length   = len_r;
    if (in_fire) begin
      xor_nxt = xor_r ^ in_rx_byte;
      case (phase_r)
        PH_SEQ: begin
          seq_nxt   = in_rx_byte;
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_nxt   = {in_rx_byte, 8'd0};
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_nxt   = {len_r[15:8], in_rx_byte};
          phase_nxt = PH_TOKEN;
        end
        PH_TOKEN: begin
          if (in_rx_byte == TOKEN_BYTE) begin
            count_nxt = '0;
            phase_nxt = (len_r == 16'd0) ? PH_CSUM : PH_BODY;
          end else begin
            phase_nxt = PH_WAIT;
          end
        end
        PH_BODY: begin
          push                     = 1'b1;
          push_data.item_kind      = KIND_BODY;
          push_data.body_byte      = in_rx_byte;
          push_data.body_index     = count_r;
          push_data.last_body_byte = is_last;
          count_nxt                = count_inc[15:0];
          if (is_last) begin
            phase_nxt = PH_CSUM;
          end
        end
        PH_CSUM: begin
          push                    = 1'b1;
          push_data.item_kind     = KIND_END;
          push_data.checksum_good = ((xor_r ^ in_rx_byte) == 8'd0);
          phase_nxt               = PH_WAIT;
        end
        default: begin
          xor_nxt   = in_rx_byte;
          phase_nxt = (in_rx_byte == START_BYTE) ? PH_SEQ : PH_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      seq_r   <= '0;
      len_r   <= '0;
      xor_r   <= '0;
      count_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      seq_r   <= seq_nxt;
      len_r   <= len_nxt;
      xor_r   <= xor_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/stkfr_queue.sv
// ----------------------------------------------------------------------------
// Frame receiver queue
// Small first-in first-out buffer between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none
module stkfr_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire stkfr_pkg::res_t       push_data,
  input  wire logic                  pop,
  output stkfr_pkg::res_t            pop_data,
  output stkfr_pkg::q_status_t       q_st
);
  import stkfr_pkg::*;

  res_t          mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic           do_push;
  logic           do_pop;

  assign q_st.full  = (count_r == (QAW+1)'(QDEPTH));
  assign q_st.empty = (count_r == '0);
  assign do_push    = push && !q_st.full;
  assign do_pop     = pop && !q_st.empty;
  assign pop_data   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QAW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (QAW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/stkfr_back.sv
// ----------------------------------------------------------------------------
// Frame receiver output stage
// Pulls result words from the queue into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module stkfr_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire stkfr_pkg::q_status_t  q_st,
  input  wire stkfr_pkg::res_t       pop_data,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output stkfr_pkg::res_t            out_res
);
  import stkfr_pkg::*;

  logic valid_r, valid_nxt;
  res_t res_r;

  assign pop       = !q_st.empty && (!valid_r || out_ready);
  assign valid_nxt = pop || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= pop_data;
    end
  end

endmodule
`default_nettype wire

// File: sv/stk500v2_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// Frame receiver top level
// Recognizes framed messages in a received byte stream and reports each
// body byte and one frame-end summary per complete frame.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   in_rx_byte
//   out_     output     out_valid / out_ready item_kind, body_byte, body_index,
//                                             last_body_byte, frame_sequence,
//                                             frame_length, checksum_good
//
// One byte word is taken per cycle while the queue is not full; the parser
// updates its state in the cycle the word is accepted. A result reaches the
// output through a four-entry queue and the output register.
// Reset is synchronous and active low; no clearing pass is needed.
// in_ready drops only while the queue is full, so an output stall backs up
// into the input once four results are queued behind the one at the output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module stk500v2_frame_receiver_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_item_kind,
  output logic [7:0]       out_body_byte,
  output logic [15:0]      out_body_index,
  output logic             out_last_body_byte,
  output logic [7:0]       out_frame_sequence,
  output logic [15:0]      out_frame_length,
  output logic             out_checksum_good
);
  import stkfr_pkg::*;

  q_status_t   q_st;
  logic        push;
  res_t        push_data;
  logic        pop;
  res_t        pop_data;
  res_t        out_res;
  logic [16:0] next_index;
  logic        out_body_word;
  logic        last_ok;
  logic        drained;

  stkfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .q_st       (q_st),
    .push       (push),
    .push_data  (push_data)
  );

  stkfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_st      (q_st)
  );

  stkfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_st      (q_st),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_item_kind      = out_res.item_kind;
  assign out_body_byte      = out_res.body_byte;
  assign out_body_index     = out_res.body_index;
  assign out_last_body_byte = out_res.last_body_byte;
  assign out_frame_sequence = out_res.frame_sequence;
  assign out_frame_length   = out_res.frame_length;
  assign out_checksum_good  = out_res.checksum_good;

  assign next_index    = {1'b0, out_body_index} + 17'd1;
  assign out_body_word = out_valid && (out_item_kind == KIND_BODY);
  assign last_ok       = ((next_index == {1'b0, out_frame_length}) == out_last_body_byte);
  assign drained       = q_st.empty && !push && (!out_valid || out_ready);

  `SVA_SAME(a_no_push_full, clk, rst_n, push, !q_st.full, "push into a full queue")
  `SVA_SAME(a_no_pop_empty, clk, rst_n, pop, !q_st.empty, "pop from an empty queue")
  `SVA_SAME(a_last_mark, clk, rst_n, out_body_word, last_ok, "last mark disagrees with length")
  `SVA_NEXT(a_empty_idle, clk, rst_n, drained, !out_valid, "output word without a queued result")

endmodule
`default_nettype wire
